// File: hdl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types, widths and command codes of the frame pacer.
// ----------------------------------------------------------------------------
package fps_pkg;

  // Event codes carried in the request's tuser
  typedef enum logic [2:0] {
    CMD_FRAME_END  = 3'd0,
    CMD_DELAY_DONE = 3'd1,
    CMD_RESET      = 3'd2,
    CMD_STOP       = 3'd3,
    CMD_RESUME     = 3'd4
  } cmd_t;

  localparam int CmdW      = 3;
  localparam int TickW     = 32;
  localparam int FrameW    = 24;
  localparam int RateW     = 16;
  localparam int DelayW    = 16;
  localparam int FracW     = 16;

  // Divider: dividend is frame_time shifted up by 8 bits
  localparam int DivW      = FrameW + 8;
  localparam int DivCntW   = $clog2(DivW);

  // Reset value of play_rate: 1.0 in Q8.8
  localparam logic [RateW-1:0] RateReset = 16'd256;

  // Skipped time after which jitter is dropped
  localparam logic [TickW-1:0] SkipClearMs = 32'd50;

  // Stream payload widths, padded to bytes
  localparam int InDataW  = 56;
  localparam int OutDataW = 48;

endpackage

// File: hdl/fps_div.sv
// ----------------------------------------------------------------------------
// fps_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fps_div
  import fps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DivW-1:0]    dividend,
  input  logic [RateW-1:0]   divisor,
  output logic               done,
  output logic [DivW-1:0]    quotient
);

  logic               busy;
  logic [DivCntW-1:0] count;
  logic [RateW-1:0]   rem;
  logic [DivW-1:0]    qr;
  logic [RateW-1:0]   dvs;
  logic [RateW:0]     trial;
  logic [RateW:0]     diff;
  logic               ge;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, qr[DivW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = ~diff[RateW];

  // Step the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        qr    <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= ge ? diff[RateW-1:0] : trial[RateW-1:0];
        qr    <= {qr[DivW-2:0], ge};
        count <= count + 1'b1;
        if (count == DivCntW'(DivW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = qr;

endmodule

// File: hdl/frame_pacer_with_skip.sv
// ----------------------------------------------------------------------------
// frame_pacer_with_skip
// Frame pacing controller with jitter compensation and frame skipping.
// ----------------------------------------------------------------------------
// Each request carries one host event (frame_end, delay_done, reset, stop,
// resume) in tuser and the millisecond tick plus frame time in tdata; every
// request yields exactly one response with the delay, the skip flag and the
// pause gap. frame_end runs the 32-step restoring divider for frame_time /
// play_rate, one bit per cycle; delay_done passes the jitter and skip states
// and other events go straight to output. One request is taken at a time;
// a finished response waits in the output register while the next request
// is accepted. The user writes play_rate through the cfg port while no
// request is in progress; the block does not enforce it. Rate 0 acts as 1.
// ----------------------------------------------------------------------------
module frame_pacer_with_skip
  import fps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // request
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // now_ms[31:0], frame_time[55:32]
  input  logic [CmdW-1:0]     s_tuser,   // cmd[2:0]
  // response
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // delay_ms[15:0], pause_gap_ms[47:16]
  output logic                m_tuser,   // skip_frame[0]
  // play_rate register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RateW-1:0]    cfg_data
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_SUM   = 8'b0000_0100,
    ST_SUB   = 8'b0000_1000,
    ST_CLAMP = 8'b0001_0000,
    ST_JIT   = 8'b0010_0000,
    ST_SKIP  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t state;

  // Block state
  logic [RateW-1:0]  play_rate;
  logic [TickW-1:0]  frame_start;
  logic [TickW-1:0]  frame_check;
  logic [FracW-1:0]  frac_acc;
  logic [DelayW-1:0] budget_ms;
  logic [TickW-1:0]  jitter;
  logic              skipping;
  logic [TickW-1:0]  skipped_time;
  logic [TickW-1:0]  stop_time;
  logic              paused;

  // Work registers
  logic [TickW-1:0]  now_r;
  logic signed [TickW+2:0] acc;
  logic [DelayW-1:0] res_delay;
  logic [TickW-1:0]  res_gap;

  // Request fields
  logic [TickW-1:0]  in_now;
  logic [FrameW-1:0] in_frame;
  logic [CmdW-1:0]   in_cmd;
  logic              accept;

  assign in_now   = s_tdata[TickW-1:0];
  assign in_frame = s_tdata[TickW+FrameW-1:TickW];
  assign in_cmd   = s_tuser;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;

  // Divider hookup
  logic              div_start;
  logic              div_done;
  logic [DivW-1:0]   div_q;
  logic [RateW-1:0]  rate_eff;

  assign div_start = accept & (in_cmd == CMD_FRAME_END);
  assign rate_eff  = (play_rate == '0) ? RateW'(1) : play_rate;

  fps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({in_frame, 8'd0}),
    .divisor  (rate_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // Budget update: accumulate the quotient onto the fraction
  logic [DivW:0]     sum;
  logic [DivW-FracW:0] whole;
  assign sum   = {1'b0, div_q} + (DivW+1)'(frac_acc);
  assign whole = sum[DivW:FracW];

  // Half jitter, rounded toward zero
  logic signed [TickW:0]   jit_rnd;
  logic signed [TickW-1:0] half_jit;
  assign jit_rnd  = $signed({jitter[TickW-1], jitter}) + $signed({{TickW{1'b0}}, jitter[TickW-1]});
  assign half_jit = TickW'(jit_rnd >>> 1);

  // Final delay before clamping
  logic signed [TickW+2:0] dval;
  assign dval = acc - (TickW+3)'(half_jit);

  // Skip bookkeeping on delay_done
  logic [TickW-1:0]        st_sum;
  logic [TickW-1:0]        jit_eff;
  logic signed [TickW:0]   budget_s;
  logic signed [TickW:0]   budget2_s;
  assign st_sum    = skipped_time + acc[TickW-1:0];
  assign jit_eff   = (st_sum > SkipClearMs) ? '0 : jitter;
  assign budget_s  = $signed({{(TickW-DelayW+1){1'b0}}, budget_ms});
  assign budget2_s = $signed({{(TickW-DelayW){1'b0}}, budget_ms, 1'b0});

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      play_rate <= RateReset;
    end else if (cfg_valid & cfg_ready) begin
      play_rate <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_start  <= '0;
      frame_check  <= '0;
      frac_acc     <= '0;
      budget_ms    <= '0;
      jitter       <= '0;
      skipping     <= 1'b0;
      skipped_time <= '0;
      stop_time    <= '0;
      paused       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // Drop the taken response unless a new one replaces it
      if (m_tvalid & m_tready & (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            now_r     <= in_now;
            res_delay <= '0;
            res_gap   <= '0;
            unique case (in_cmd)
              CMD_FRAME_END: begin
                state <= ST_DIV;
              end
              CMD_DELAY_DONE: begin
                state <= ST_JIT;
              end
              CMD_RESET: begin
                frame_start <= in_now;
                frame_check <= in_now;
                frac_acc    <= '0;
                jitter      <= '0;
                skipping    <= 1'b0;
                paused      <= 1'b0;
                state       <= ST_OUT;
              end
              CMD_STOP: begin
                if (!paused) begin
                  stop_time <= in_now;
                  paused    <= 1'b1;
                end
                state <= ST_OUT;
              end
              CMD_RESUME: begin
                if (paused) begin
                  frame_start <= in_now;
                  frame_check <= in_now;
                  frac_acc    <= '0;
                  jitter      <= '0;
                  skipping    <= 1'b0;
                  paused      <= 1'b0;
                  res_gap     <= in_now - stop_time;
                end
                state <= ST_OUT;
              end
              default: begin
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          // Take whole milliseconds as budget, keep the fraction
          budget_ms <= (whole > (DivW-FracW+1)'(16'hFFFF)) ? 16'hFFFF
                                                           : whole[DelayW-1:0];
          frac_acc  <= sum[FracW-1:0];
          acc       <= $signed({3'b000, now_r - frame_start});
          state     <= ST_SUB;
        end
        ST_SUB: begin
          acc   <= $signed({{(TickW-DelayW+3){1'b0}}, budget_ms}) - acc;
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          // Clamp to 0..65535, drop the wait while skipping
          if (skipping || dval < 0) begin
            res_delay <= '0;
          end else if (dval > (TickW+3)'(16'hFFFF)) begin
            res_delay <= 16'hFFFF;
          end else begin
            res_delay <= dval[DelayW-1:0];
          end
          state <= ST_OUT;
        end
        ST_JIT: begin
          // Measure frame length and fold the miss into jitter
          acc         <= $signed({3'b000, now_r - frame_check});
          jitter      <= jitter + (now_r - frame_check) - TickW'(budget_ms);
          frame_start <= now_r;
          frame_check <= now_r;
          state       <= ST_SKIP;
        end
        ST_SKIP: begin
          if (skipping) begin
            skipped_time <= st_sum;
            jitter       <= jit_eff;
            if ($signed({jit_eff[TickW-1], jit_eff}) < budget_s) begin
              skipping <= 1'b0;
            end
          end else if ($signed({jitter[TickW-1], jitter}) > budget2_s) begin
            skipping     <= 1'b1;
            skipped_time <= '0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          // Hand the response over once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_gap, res_delay};
            m_tuser  <= skipping;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame pacer. A short table of host events
// covers field extremes, every event code, pause handling, skip entry and
// exit, saturated budgets and the play_rate corners. Then several phases of
// a simulated host loop (frame_end, wait, delay_done) with random timing,
// pauses, restarts and junk events follow; each phase first writes play_rate.
// Responses are checked against table values or an in-bench pacing model.
// ----------------------------------------------------------------------------
module testbench;
  import fps_pkg::*;

  localparam int          KeepRate     = -1;
  localparam int          NumPhases    = 8;
  localparam int          PhaseItems   = 195;
  localparam int          IdleLimit    = 3000;
  localparam int          TailCycles   = 60;
  localparam logic [2:0]  CmdSpareA    = 3'd5;
  localparam logic [2:0]  CmdSpareB    = 3'd6;
  localparam logic [2:0]  CmdSpareC    = 3'd7;

  typedef struct {
    logic [2:0]        cmd;
    logic [TickW-1:0]  now;
    logic [FrameW-1:0] ft;
  } pace_req_t;

  typedef struct {
    logic [DelayW-1:0] delay;
    logic              skip;
    logic [TickW-1:0]  gap;
  } pace_rsp_t;

  typedef struct {
    int                rate;
    logic [2:0]        cmd;
    logic [TickW-1:0]  now;
    logic [FrameW-1:0] ft;
    bit                typed;
    pace_rsp_t         want;
  } plan_row_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic [CmdW-1:0]     s_tuser   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RateW-1:0]    cfg_data  = '0;

  // Predictor state
  logic [RateW-1:0]  rate_cur  = RateReset;
  logic [TickW-1:0]  mark_start = '0;
  logic [TickW-1:0]  mark_check = '0;
  logic [FracW-1:0]  frac_ms   = '0;
  logic [DelayW-1:0] budget    = '0;
  logic [TickW-1:0]  jit       = '0;
  logic              skip_on   = 1'b0;
  logic [TickW-1:0]  skip_ms   = '0;
  logic [TickW-1:0]  halt_ms   = '0;
  logic              halted    = 1'b0;

  pace_rsp_t   pending_rsp[$];
  plan_row_t   plan_q[$];
  pace_rsp_t   no_rsp = '{16'd0, 1'b0, 32'd0};
  int          n_fail = 0;
  int          sent_total = 0;
  int          burst_left = 0;
  int          gap_max = 0;
  logic [31:0] host_ms = '0;

  frame_pacer_with_skip u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Restart frame timing, as on reset and on resume from a pause
  function automatic void restart_pacing(input logic [TickW-1:0] now);
    mark_start = now;
    mark_check = now;
    frac_ms    = '0;
    jit        = '0;
    skip_on    = 1'b0;
    halted     = 1'b0;
  endfunction

  // Advance the pacing state by one host event and return its response
  function automatic pace_rsp_t pace_event(input pace_req_t r);
    longint unsigned dividend, divisor, total;
    longint          b_l, s_l, j_l, wait_ms;
    logic [TickW-1:0] span;
    pace_rsp_t       rsp;
    rsp = no_rsp;
    unique case (r.cmd)
      CMD_FRAME_END: begin
        dividend = 64'({r.ft, 8'h00});
        divisor  = (rate_cur == '0) ? 64'd1 : 64'(rate_cur);
        total    = 64'(frac_ms) + dividend / divisor;
        budget   = ((total >> 16) > 64'hFFFF) ? 16'hFFFF : total[31:16];
        frac_ms  = total[15:0];
        if (!skip_on) begin
          span    = r.now - mark_start;
          b_l     = longint'(budget);
          s_l     = longint'(span);
          j_l     = longint'($signed(jit));
          wait_ms = b_l - s_l - j_l / 2;
          if (wait_ms < 0) wait_ms = 0;
          if (wait_ms > 65535) wait_ms = 65535;
          rsp.delay = wait_ms[15:0];
        end
      end
      CMD_DELAY_DONE: begin
        span       = r.now - mark_check;
        mark_start = r.now;
        jit        = jit + span - {16'h0, budget};
        j_l        = longint'($signed(jit));
        b_l        = longint'(budget);
        if (skip_on) begin
          skip_ms = skip_ms + span;
          if (skip_ms > SkipClearMs) begin
            jit = '0;
            j_l = 0;
          end
          if (j_l < b_l) skip_on = 1'b0;
        end else if (j_l > 2 * b_l) begin
          skip_on = 1'b1;
          skip_ms = '0;
        end
        mark_check = r.now;
      end
      CMD_RESET: restart_pacing(r.now);
      CMD_STOP: begin
        if (!halted) begin
          halt_ms = r.now;
          halted  = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (halted) begin
          restart_pacing(r.now);
          rsp.gap = r.now - halt_ms;
        end
      end
      default: ;
    endcase
    rsp.skip = skip_on;
    return rsp;
  endfunction

  function automatic void plan(input int rate, input logic [2:0] cmd,
                               input logic [31:0] now, input logic [23:0] ft,
                               input bit typed, input logic [15:0] delay,
                               input logic skip, input logic [31:0] gap);
    plan_row_t row;
    row.rate  = rate;
    row.cmd   = cmd;
    row.now   = now;
    row.ft    = ft;
    row.typed = typed;
    row.want  = '{delay, skip, gap};
    plan_q.push_back(row);
  endfunction

  // Drop valid unless it is already low
  task automatic idle_sender();
    if (s_tvalid) s_tvalid <= 1'b0;
  endtask

  // Hold off requests until every response is back
  task automatic drain();
    idle_sender();
    burst_left = 0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_play_rate(input logic [RateW-1:0] rate);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= rate;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rate_cur = rate;
  endtask

  // Send one request in bursts with random gaps; record its expected response
  task automatic send_event(input logic [2:0] cmd, input logic [31:0] now,
                            input logic [23:0] ft, input bit typed,
                            input pace_rsp_t want, output pace_rsp_t got);
    int        gap;
    pace_req_t r;
    r = '{cmd, now, ft};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        idle_sender();
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {r.ft, r.now};
    s_tuser  <= r.cmd;
    do @(posedge clk); while (!s_tready);
    got = pace_event(r);
    pending_rsp.push_back(typed ? want : got);
    sent_total++;
  endtask

  function automatic logic [23:0] pick_frame_time();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'($urandom_range(24'h040000, 24'h300000));
  endfunction

  // One step of the simulated host: mostly a frame loop, sometimes pauses,
  // restarts, back pressure or junk events
  task automatic host_step();
    int        pick, lag;
    pace_rsp_t got;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      host_ms += $urandom_range(0, 6);
      send_event(CMD_FRAME_END, host_ms, pick_frame_time(), 1'b0, no_rsp, got);
      if (!got.skip && $urandom_range(0, 9) != 0) host_ms += 32'(got.delay);
      lag = $urandom_range(0, 99);
      if (lag < 80) host_ms += $urandom_range(0, 2);
      else if (lag < 95) host_ms += $urandom_range(10, 80);
      else host_ms += $urandom_range(100, 800);
      send_event(CMD_DELAY_DONE, host_ms, 24'($urandom), 1'b0, no_rsp, got);
    end else if (pick < 86) begin
      send_event(CMD_STOP, host_ms, 24'($urandom), 1'b0, no_rsp, got);
      host_ms += $urandom_range(0, 3000);
      if ($urandom_range(0, 4) == 0)
        send_event(CMD_STOP, host_ms, 24'($urandom), 1'b0, no_rsp, got);
      host_ms += $urandom_range(0, 3000);
      send_event(CMD_RESUME, host_ms, 24'($urandom), 1'b0, no_rsp, got);
    end else if (pick < 89) begin
      send_event(CMD_RESET, host_ms, 24'($urandom), 1'b0, no_rsp, got);
    end else if (pick < 90) begin
      drain();
    end else begin
      send_event(3'($urandom_range(0, 7)), $urandom, 24'($urandom), 1'b0, no_rsp,
                 got);
    end
  endtask

  // Receiver: ready pattern cycles through clean, light and heavy stalling
  int rx_cycle = 0;
  int rx_hold  = 0;
  always @(posedge clk) begin
    int window;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      window = (rx_cycle / 400) % 3;
      if (rx_hold != 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (window == 1 && $urandom_range(0, 99) < 20) begin
        rx_hold = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else if (window == 2 && $urandom_range(0, 99) < 40) begin
        rx_hold = $urandom_range(0, 39);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each response with the oldest expectation
  always @(posedge clk) begin
    pace_rsp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding");
        n_fail++;
      end else begin
        want = pending_rsp.pop_front();
        if (m_tdata[15:0] !== want.delay) begin
          $error("delay_ms: expected %0d, got %0d", want.delay, m_tdata[15:0]);
          n_fail++;
        end
        if (m_tuser !== want.skip) begin
          $error("skip_frame: expected %0b, got %0b", want.skip, m_tuser);
          n_fail++;
        end
        if (m_tdata[47:16] !== want.gap) begin
          $error("pause_gap_ms: expected %0d, got %0d", want.gap, m_tdata[47:16]);
          n_fail++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IdleLimit) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t   row;
    pace_rsp_t   got;
    logic [15:0] rate;
    int          goal;

    // Directed events: rate, event, tick, frame time, typed, delay, skip, gap
    plan(KeepRate, CMD_FRAME_END,  32'h0000_0000, 24'h000000, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CMD_FRAME_END,  32'h0000_0000, 24'hFFFFFF, 1, 16'd255,   0, 32'd0);
    plan(KeepRate, CMD_STOP,       32'd100,       24'h000000, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CMD_STOP,       32'd200,       24'hFFFFFF, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CMD_RESUME,     32'hFFFF_FFFF, 24'h000000, 1, 16'd0,     0, 32'hFFFF_FF9B);
    plan(KeepRate, CMD_RESUME,     32'd5,         24'h000000, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CMD_FRAME_END,  32'd4,         24'hFFFFFF, 1, 16'd250,   0, 32'd0);
    plan(KeepRate, CMD_DELAY_DONE, 32'd300,       24'h000000, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CMD_DELAY_DONE, 32'd2000,      24'h000000, 1, 16'd0,     1, 32'd0);
    plan(KeepRate, CMD_FRAME_END,  32'd2001,      24'h000000, 1, 16'd0,     1, 32'd0);
    plan(KeepRate, CMD_DELAY_DONE, 32'd2010,      24'h000000, 1, 16'd0,     1, 32'd0);
    plan(KeepRate, CMD_DELAY_DONE, 32'd2100,      24'h000000, 1, 16'd0,     1, 32'd0);
    plan(KeepRate, CMD_FRAME_END,  32'd2101,      24'hFFFFFF, 1, 16'd0,     1, 32'd0);
    plan(KeepRate, CMD_DELAY_DONE, 32'd2110,      24'h000000, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CmdSpareA,      32'hA5A5_5A5A, 24'h5A5A5A, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CmdSpareB,      32'hFFFF_FFFF, 24'hFFFFFF, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CmdSpareC,      32'h1234_5678, 24'h000001, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CMD_RESET,      32'h8000_0000, 24'h000000, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CMD_FRAME_END,  32'h7FFF_FFFF, 24'h000000, 1, 16'd0,     0, 32'd0);
    plan(1,        CMD_FRAME_END,  32'h8000_0000, 24'hFFFFFF, 1, 16'd65535, 0, 32'd0);
    plan(KeepRate, CMD_DELAY_DONE, 32'h8000_0000, 24'h000000, 1, 16'd0,     0, 32'd0);
    plan(KeepRate, CMD_FRAME_END,  32'h8000_0000, 24'hFFFFFF, 1, 16'd65535, 0, 32'd0);
    plan(65535,    CMD_FRAME_END,  32'h8000_0010, 24'h000001, 1, 16'd32751, 0, 32'd0);
    plan(0,        CMD_FRAME_END,  32'h8000_0010, 24'h000001, 0, 16'd0,     0, 32'd0);
    plan(KeepRate, CMD_STOP,       32'h0000_0000, 24'h000000, 0, 16'd0,     0, 32'd0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    gap_max = 4;
    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.rate != KeepRate) write_play_rate(row.rate[15:0]);
      send_event(row.cmd, row.now, row.ft, row.typed, row.want, got);
    end

    // Random host phases, one play_rate each
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       rate = RateReset;
        1:       rate = 16'hFFFF;
        2:       rate = 16'd1;
        3:       rate = 16'($urandom_range(1, 65535));
        default: rate = 16'($urandom_range(64, 1024));
      endcase
      write_play_rate(rate);
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 30);
      host_ms = (p == 1) ? 32'hFFFF_F000 : $urandom;
      send_event(CMD_RESET, host_ms, 24'($urandom), 1'b0, no_rsp, got);
      goal = sent_total + PhaseItems;
      while (sent_total < goal) host_step();
    end

    drain();
    repeat (TailCycles) @(posedge clk);
    if (n_fail == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
